// ===== rtl/efr_pkg.sv =====
// package for the escaped line framer
// types, register codes and defaults shared by efr_cfg_regs and escaped_line_framer_unit
`default_nettype none

package efr_pkg;

    localparam int LINE_BYTES_DEF = 64;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_LINE_END = 1'b0;
    localparam logic REG_ESCAPE   = 1'b1;

    localparam logic [7:0] LINE_END_RST = 8'd10;
    localparam logic [7:0] ESCAPE_RST   = 8'd92;

    // tuser code on the input side
    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] line_end_char;
        logic [7:0] escape_char;
    } efr_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_ERR
    } efr_state_t;

endpackage

`default_nettype wire

// ===== rtl/escaped_line_framer_unit.sv =====
// escaped line framer top level: line store memory, control and output register
// uses efr_pkg and efr_cfg_regs
//
//  channel   dir  ports                        transaction
//  s_        in   s_tvalid/s_tready/tdata/user one text byte or a flush request
//  m_        out  m_tvalid/m_tready/tdata/...  one byte of a line, or an error
//  apb       in   psel/penable/pwrite/paddr    terminator and escape registers
//
// a data byte is written into the line store
// a completed line of n stored bytes streams out, one byte per cycle while m_tready is high,
// n + 1 results, after a registered read of the store
// input is held off while a line or an error result is being produced
// m_tready low stalls the read of the store; reset clears all control state
`default_nettype none

module escaped_line_framer_unit #(
    parameter int LINE_BYTES = efr_pkg::LINE_BYTES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // in_byte[7:0]
    input  wire logic [0:0]                     s_tuser,   // req_type[0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [39:0]                    m_tdata,   // out_byte[7:0], line_number[39:8]
    output logic                                m_tlast,
    output logic      [0:0]                     m_tuser,   // overflow_error[0]
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [efr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [efr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [efr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import efr_pkg::*;

    localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CW = $clog2(LINE_BYTES + 1);

    efr_cfg_t   cfg;
    efr_state_t state_reg, state_next;

    logic [7:0]    line_mem [LINE_BYTES];
    logic [7:0]    mem_rdata;

    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [31:0]   line_cnt_reg, line_cnt_next;
    logic          esc_reg, esc_next;
    logic          disc_reg, disc_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          err_cnt_reg, err_cnt_next;

    logic          m_valid_reg;
    logic [7:0]    m_byte_reg;
    logic [31:0]   m_num_reg;
    logic          m_last_reg;
    logic          m_err_reg;

    logic          in_acc;
    logic          is_flush;
    logic          ends;
    logic          full;
    logic          is_esc;
    logic          go_emit;
    logic          go_err;
    logic          start_now;
    logic          store;
    logic          out_free;
    logic          rd_issue;
    logic          load_byte;
    logic          load_term;
    logic          load_err;

    efr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_acc   = s_tvalid && s_tready;
    assign is_flush = (s_tuser[0] == REQ_FLUSH);
    assign ends     = (s_tdata == cfg.line_end_char) && !esc_reg;
    assign is_esc   = (s_tdata == cfg.escape_char);
    assign full     = (fill_reg == CW'(LINE_BYTES));
    assign out_free = !m_valid_reg || m_tready;

    // input decode
    always_comb begin
        go_emit      = 1'b0;
        go_err       = 1'b0;
        start_now    = 1'b0;
        store        = 1'b0;
        esc_next     = esc_reg;
        disc_next    = disc_reg;
        err_cnt_next = err_cnt_reg;
        if (in_acc) begin
            if (is_flush) begin
                if (disc_reg) begin
                    disc_next = 1'b0;
                    start_now = 1'b1;
                    esc_next  = 1'b0;
                end else if (fill_reg == '0) begin
                    esc_next = 1'b0;
                end else if (full) begin
                    go_err       = 1'b1;
                    err_cnt_next = 1'b1;
                end else begin
                    go_emit = 1'b1;
                end
            end else if (disc_reg) begin
                if (ends) begin
                    disc_next = 1'b0;
                    start_now = 1'b1;
                end else begin
                    esc_next = is_esc;
                end
            end else if (ends) begin
                if (fill_reg == '0) begin
                    start_now = 1'b1;
                end else if (full) begin
                    go_err       = 1'b1;
                    err_cnt_next = 1'b1;
                end else begin
                    go_emit = 1'b1;
                end
            end else if (full) begin
                go_err       = 1'b1;
                err_cnt_next = 1'b0;
                disc_next    = 1'b1;
                esc_next     = is_esc;
            end else begin
                store    = 1'b1;
                esc_next = is_esc;
            end
        end
        if (load_term) begin
            esc_next = 1'b0;
        end
        if (load_err && err_cnt_reg) begin
            esc_next = 1'b0;
        end
    end

    // read-out control
    assign rd_issue  = (state_reg == ST_EMIT) && (rd_ptr_reg < fill_reg)
                       && (!rd_pend_reg || out_free);
    assign load_byte = (state_reg == ST_EMIT) && rd_pend_reg && out_free;
    assign load_term = (state_reg == ST_EMIT) && !rd_pend_reg
                       && (rd_ptr_reg == fill_reg) && out_free;
    assign load_err  = (state_reg == ST_ERR) && out_free;

    always_comb begin
        rd_pend_next = rd_pend_reg;
        if (rd_issue) begin
            rd_pend_next = 1'b1;
        end else if (load_byte) begin
            rd_pend_next = 1'b0;
        end
    end

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        if (go_emit) begin
            rd_ptr_next = '0;
        end else if (rd_issue) begin
            rd_ptr_next = rd_ptr_reg + CW'(1);
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (start_now || load_term || (load_err && err_cnt_reg)) begin
            fill_next = '0;
        end else if (store) begin
            fill_next = fill_reg + CW'(1);
        end
    end

    always_comb begin
        line_cnt_next = line_cnt_reg;
        if (start_now || load_term || (load_err && err_cnt_reg)) begin
            line_cnt_next = line_cnt_reg + 32'd1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (go_emit) begin
                    state_next = ST_EMIT;
                end else if (go_err) begin
                    state_next = ST_ERR;
                end
            end
            ST_EMIT: begin
                if (load_term) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (load_err) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EMIT: s_tready = 1'b0;
            ST_ERR:  s_tready = 1'b0;
            default: s_tready = 1'b0;
        endcase
    end

    // line store
    always_ff @(posedge aclk) begin
        if (store) begin
            line_mem[fill_reg[AW-1:0]] <= s_tdata;
        end
        if (rd_issue) begin
            mem_rdata <= line_mem[rd_ptr_reg[AW-1:0]];
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (load_byte) begin
            m_byte_reg <= mem_rdata;
            m_last_reg <= 1'b0;
            m_err_reg  <= 1'b0;
            m_num_reg  <= line_cnt_reg;
        end else if (load_term) begin
            m_byte_reg <= cfg.line_end_char;
            m_last_reg <= 1'b1;
            m_err_reg  <= 1'b0;
            m_num_reg  <= line_cnt_reg;
        end else if (load_err) begin
            m_byte_reg <= 8'd0;
            m_last_reg <= 1'b1;
            m_err_reg  <= 1'b1;
            m_num_reg  <= line_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            rd_ptr_reg   <= '0;
            line_cnt_reg <= '0;
            esc_reg      <= 1'b0;
            disc_reg     <= 1'b0;
            rd_pend_reg  <= 1'b0;
            err_cnt_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            rd_ptr_reg   <= rd_ptr_next;
            line_cnt_reg <= line_cnt_next;
            esc_reg      <= esc_next;
            disc_reg     <= disc_next;
            rd_pend_reg  <= rd_pend_next;
            err_cnt_reg  <= err_cnt_next;
            if (load_byte || load_term || load_err) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_num_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

endmodule

`default_nettype wire

// ===== rtl/efr_cfg_regs.sv =====
// apb register file for the escaped line framer
// holds the terminator and escape byte values; uses efr_pkg
`default_nettype none

module efr_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [efr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [efr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [efr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output efr_pkg::efr_cfg_t                   cfg
);
    import efr_pkg::*;

    efr_cfg_t cfg_reg;
    efr_cfg_t cfg_next;
    logic     wr_en;
    logic     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_LINE_END: cfg_next.line_end_char = pwdata[7:0];
                REG_ESCAPE:   cfg_next.escape_char   = pwdata[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LINE_END: prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_reg.line_end_char};
            REG_ESCAPE:   prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_reg.escape_char};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_end_char <= LINE_END_RST;
            cfg_reg.escape_char   <= ESCAPE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire
